FILE: hdl/csk_pkg.sv
// Shared types and constants for the comb sorter with key and payload.
`timescale 1ns / 1ps
`default_nettype none

package csk_pkg;

   // Field widths of one record
   localparam int KEY_W   = 32;
   localparam int POS_W   = 6;
   localparam int FLIPS_W = 64;

   // gap * 10 / 13 == (gap * 12610) >> 14, exact for every gap below 182
   localparam int SHRINK_MUL   = 12610;
   localparam int SHRINK_SHIFT = 14;

   // One stored record: key moves with its payload
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0]        position;
      logic [FLIPS_W-1:0]      flips;
   } csk_record_type;

   // Marks a memory read whose data goes out as a result beat
   typedef struct packed {
      logic valid;
      logic last;
   } csk_emit_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_RD_I,
      ST_RD_J,
      ST_CMP,
      ST_WR_J,
      ST_PASS_END,
      ST_EMIT
   } csk_state_type;

endpackage

`default_nettype wire

FILE: hdl/comb_sort_key_payload.sv
// Top level: record memory, sort sequencer and registered result output.
`timescale 1ns / 1ps
`default_nettype none

// Comb sorter for records of a signed 32-bit key with a position and flip-mask
// payload. A record is taken on each clock with start high and busy low, into
// the record memory. The record with req_last_item set (stored too, unless
// MAX_ITEMS records are already held) raises busy and starts the sort, or the
// output if only one record is held. The sort runs passes with the gap shrunk
// by 10/13 down to one, then gap-one passes until one makes no swap. Every
// compare takes two reads on the single read port of the memory and the
// compare, plus the second write of a swap, and each pass ends in a pass-end
// step. The sorted set then streams out one beat per cycle on rsp_valid, each
// beat through the memory read register and the output register, with
// rsp_end_of_run on the final beat. The result channel cannot stall, so every
// beat must be taken when shown. busy drops once the last result read is
// issued; a new set may load while the final beats are still draining.
module comb_sort_key_payload #(
   parameter int MAX_ITEMS = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire signed [31:0]                req_key,
   input  wire [5:0]                        req_position,
   input  wire [63:0]                       req_flips,
   input  wire                              req_last_item,
   output logic                             rsp_valid,
   output logic signed [31:0]               rsp_sorted_key,
   output logic [5:0]                       rsp_sorted_position,
   output logic [63:0]                      rsp_sorted_flips,
   output logic                             rsp_end_of_run
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);

   csk_pkg::csk_record_type req_rec;
   csk_pkg::csk_record_type rd_data;
   csk_pkg::csk_record_type mem_wdata;
   csk_pkg::csk_emit_type   emit;
   csk_pkg::csk_emit_type   emit_d_ff, emit_d_in;
   logic                    mem_we;
   logic                    mem_re;
   logic [AW-1:0]           mem_waddr;
   logic [AW-1:0]           mem_raddr;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_last_ff;
   csk_pkg::csk_record_type rsp_rec_ff;

   // Pack the request beat
   always_comb begin
      req_rec.key      = req_key;
      req_rec.position = req_position;
      req_rec.flips    = req_flips;
   end

   csk_ctrl #(
      .MAX_ITEMS (MAX_ITEMS),
      .AW        (AW),
      .CW        (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_rec   (req_rec),
      .req_last  (req_last_item),
      .busy      (busy),
      .rd_data   (rd_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .emit      (emit)
   );

   csk_mem #(
      .DEPTH (MAX_ITEMS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .re      (mem_re),
      .raddr   (mem_raddr),
      .rd_data (rd_data)
   );

   // Result tag follows the memory read latency, then the output register
   assign emit_d_in    = emit;
   assign rsp_valid_in = emit_d_ff.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_d_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emit_d_ff    <= emit_d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output beat payload
   always_ff @(posedge clock) begin
      if (emit_d_ff.valid) begin
         rsp_rec_ff  <= rd_data;
         rsp_last_ff <= emit_d_ff.last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sorted_key      = rsp_rec_ff.key;
   assign rsp_sorted_position = rsp_rec_ff.position;
   assign rsp_sorted_flips    = rsp_rec_ff.flips;
   assign rsp_end_of_run      = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/csk_mem.sv
// Record memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module csk_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire                         clock,
   input  wire                         we,
   input  wire [AW-1:0]                waddr,
   input  csk_pkg::csk_record_type     wdata,
   input  wire                         re,
   input  wire [AW-1:0]                raddr,
   output csk_pkg::csk_record_type     rd_data
);

   csk_pkg::csk_record_type store [DEPTH];
   csk_pkg::csk_record_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         store[waddr] <= wdata;
      end
   end

   // Read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= store[raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/csk_ctrl.sv
// Sequencer: loads records, runs the comb sort passes, streams the result reads.
`timescale 1ns / 1ps
`default_nettype none

module csk_ctrl #(
   parameter int MAX_ITEMS = 64,
   parameter int AW        = 6,
   parameter int CW        = 7
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  csk_pkg::csk_record_type     req_rec,
   input  wire                         req_last,
   output logic                        busy,
   input  csk_pkg::csk_record_type     rd_data,
   output logic                        mem_we,
   output logic [AW-1:0]               mem_waddr,
   output csk_pkg::csk_record_type     mem_wdata,
   output logic                        mem_re,
   output logic [AW-1:0]               mem_raddr,
   output csk_pkg::csk_emit_type       emit
);

   localparam int SW = CW + 1;
   localparam int PW = CW + csk_pkg::SHRINK_SHIFT;

   csk_pkg::csk_state_type  state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           gap_ff, gap_in;
   logic                    swap_ff, swap_in;
   logic [AW-1:0]           i_ff, i_in;
   csk_pkg::csk_record_type rec_i_ff;

   logic                    accept;
   logic                    full;
   logic [CW-1:0]           load_n;
   logic [SW-1:0]           j_wide;
   logic [SW-1:0]           next_j_wide;
   logic                    more;
   logic                    greater;
   logic                    emit_last;
   logic [CW-1:0]           shrink_src;
   logic [PW-1:0]           shrink_prod;
   logic [CW-1:0]           shrink_q;
   logic [CW-1:0]           shrunk;

   // Handshake and load bookkeeping
   assign accept = start && (state_ff == csk_pkg::ST_LOAD);
   assign full   = (count_ff == CW'(MAX_ITEMS));
   assign load_n = full ? count_ff : count_ff + CW'(1);

   // Compare partner index and end-of-pass test
   assign j_wide      = SW'(i_ff) + SW'(gap_ff);
   assign next_j_wide = j_wide + SW'(1);
   assign more        = (next_j_wide < SW'(count_ff));
   assign greater     = (rec_i_ff.key > rd_data.key);
   assign emit_last   = ((SW'(i_ff) + SW'(1)) == SW'(count_ff));

   // Gap shrink by 10/13 through a constant reciprocal, floor at one
   assign shrink_src  = (state_ff == csk_pkg::ST_INIT) ? count_ff : gap_ff;
   assign shrink_prod = PW'(shrink_src) * PW'(csk_pkg::SHRINK_MUL);
   assign shrink_q    = shrink_prod[csk_pkg::SHRINK_SHIFT +: CW];
   assign shrunk      = (shrink_q == '0) ? CW'(1) : shrink_q;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csk_pkg::ST_LOAD: begin
            if (accept && req_last) begin
               state_in = (load_n > CW'(1)) ? csk_pkg::ST_INIT : csk_pkg::ST_EMIT;
            end
         end
         csk_pkg::ST_INIT:  state_in = csk_pkg::ST_RD_I;
         csk_pkg::ST_RD_I:  state_in = csk_pkg::ST_RD_J;
         csk_pkg::ST_RD_J:  state_in = csk_pkg::ST_CMP;
         csk_pkg::ST_CMP: begin
            if (greater) begin
               state_in = csk_pkg::ST_WR_J;
            end else begin
               state_in = more ? csk_pkg::ST_RD_I : csk_pkg::ST_PASS_END;
            end
         end
         csk_pkg::ST_WR_J: begin
            state_in = more ? csk_pkg::ST_RD_I : csk_pkg::ST_PASS_END;
         end
         csk_pkg::ST_PASS_END: begin
            if ((gap_ff == CW'(1)) && !swap_ff) begin
               state_in = csk_pkg::ST_EMIT;
            end else begin
               state_in = csk_pkg::ST_RD_I;
            end
         end
         csk_pkg::ST_EMIT: begin
            if (emit_last) begin
               state_in = csk_pkg::ST_LOAD;
            end
         end
         default: state_in = csk_pkg::ST_LOAD;
      endcase
   end

   // Outputs: memory port controls, result read tags, busy
   always_comb begin
      busy      = (state_ff != csk_pkg::ST_LOAD);
      mem_we    = 1'b0;
      mem_waddr = i_ff;
      mem_wdata = rd_data;
      mem_re    = 1'b0;
      mem_raddr = i_ff;
      emit      = '0;
      unique case (state_ff)
         csk_pkg::ST_LOAD: begin
            mem_we    = accept && !full;
            mem_waddr = count_ff[AW-1:0];
            mem_wdata = req_rec;
         end
         csk_pkg::ST_RD_I: begin
            mem_re = 1'b1;
         end
         csk_pkg::ST_RD_J: begin
            mem_re    = 1'b1;
            mem_raddr = j_wide[AW-1:0];
         end
         csk_pkg::ST_CMP: begin
            // lower slot takes the smaller record
            mem_we = greater;
         end
         csk_pkg::ST_WR_J: begin
            mem_we    = 1'b1;
            mem_waddr = j_wide[AW-1:0];
            mem_wdata = rec_i_ff;
         end
         csk_pkg::ST_EMIT: begin
            mem_re     = 1'b1;
            emit.valid = 1'b1;
            emit.last  = emit_last;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      count_in = count_ff;
      gap_in   = gap_ff;
      swap_in  = swap_ff;
      i_in     = i_ff;
      unique case (state_ff)
         csk_pkg::ST_LOAD: begin
            i_in = '0;
            if (accept && !full) begin
               count_in = count_ff + CW'(1);
            end
         end
         csk_pkg::ST_INIT: begin
            gap_in  = shrunk;
            swap_in = 1'b0;
            i_in    = '0;
         end
         csk_pkg::ST_CMP: begin
            if (greater) begin
               swap_in = 1'b1;
            end else begin
               i_in = i_ff + AW'(1);
            end
         end
         csk_pkg::ST_WR_J: begin
            i_in = i_ff + AW'(1);
         end
         csk_pkg::ST_PASS_END: begin
            i_in    = '0;
            swap_in = 1'b0;
            if (gap_ff != CW'(1)) begin
               gap_in = shrunk;
            end
         end
         csk_pkg::ST_EMIT: begin
            i_in = i_ff + AW'(1);
            if (emit_last) begin
               count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csk_pkg::ST_LOAD;
         count_ff <= '0;
         gap_ff   <= '0;
         swap_ff  <= 1'b0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         gap_ff   <= gap_in;
         swap_ff  <= swap_in;
         i_ff     <= i_in;
      end
   end

   // Hold the lower record of the compared pair
   always_ff @(posedge clock) begin
      if (state_ff == csk_pkg::ST_RD_J) begin
         rec_i_ff <= rd_data;
      end
   end

   // Single-port-per-direction memory: never write and read in one cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("record memory written and read in the same cycle");

   // Compare partner lies inside the loaded set and the gap is live
   a_pair_in_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == csk_pkg::ST_RD_J) |-> ((j_wide < SW'(count_ff)) && (gap_ff != '0)))
      else $error("compare partner outside the loaded set");

   // The last result read returns the block to loading with an empty set
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit.last) |=> ((state_ff == csk_pkg::ST_LOAD) && (count_ff == '0)))
      else $error("set not cleared after the final result");

   // Fill count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("record count beyond store depth");

endmodule

`default_nettype wire
